// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, ignored while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/abs_pkg.sv
// ---------------------------------------------------------------------------
// Block size controller package
// Widths, register indexes, reason codes and size derivation.
// ---------------------------------------------------------------------------
package abs_pkg;

   // Field widths.
   localparam int TIME_W   = 20;
   localparam int FRAMES_W = 16;
   localparam int RATE_W   = 18;
   localparam int SIZE_W   = 16;
   localparam int FACTOR_W = 16;
   localparam int REASON_W = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 18;
   localparam int FSS_W    = 32;

   // Default window depth.
   localparam int HISTORY_DEPTH_DEF = 32;

   // Microseconds per second, used in the cross-multiplied compare.
   localparam int USEC_W = 20;
   localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
   localparam int Q_FRAC_W = 12;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_SIZE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_OVER   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_UNDER  = 3'd7;

   // Reset values of the registers.
   localparam logic [RATE_W-1:0]   RATE_RST        = 18'd48000;
   localparam logic [RATE_W-1:0]   RATE_DEF        = 18'd48000;
   localparam logic [SIZE_W-1:0]   SMALL_RST       = 16'd64;
   localparam logic [SIZE_W-1:0]   NORMAL_RST      = 16'd256;
   localparam logic [SIZE_W-1:0]   LARGE_RST       = 16'd1024;
   localparam logic [FACTOR_W-1:0] UPPER_RST       = 16'd3277;
   localparam logic [FACTOR_W-1:0] LOWER_RST       = 16'd1638;
   localparam logic [FACTOR_W-1:0] FAST_OVER_RST   = 16'd4096;
   localparam logic [FACTOR_W-1:0] FAST_UNDER_RST  = 16'd819;
   localparam logic [SIZE_W-1:0]   SIZE_MIN        = 16'd16;

   // Reason codes.
   localparam logic [REASON_W-1:0] RSN_NONE       = 3'd0;
   localparam logic [REASON_W-1:0] RSN_FAST_DOWN  = 3'd1;
   localparam logic [REASON_W-1:0] RSN_FAST_UP    = 3'd2;
   localparam logic [REASON_W-1:0] RSN_SLOW_DOWN  = 3'd3;
   localparam logic [REASON_W-1:0] RSN_SLOW_UP    = 3'd4;
   localparam logic [REASON_W-1:0] RSN_UNDERRUN   = 3'd5;

   typedef struct packed {
      logic [SIZE_W-1:0] small_sz;
      logic [SIZE_W-1:0] normal_sz;
      logic [SIZE_W-1:0] large_sz;
   } sizes_type;

   // Effective sizes: small at least the minimum, then monotonic.
   function automatic sizes_type derive_sizes(input logic [SIZE_W-1:0] s_req,
                                              input logic [SIZE_W-1:0] n_req,
                                              input logic [SIZE_W-1:0] l_req);
      sizes_type r;
      r.small_sz  = (s_req < SIZE_MIN) ? SIZE_MIN : s_req;
      r.normal_sz = (n_req < r.small_sz) ? r.small_sz : n_req;
      r.large_sz  = (l_req < r.normal_sz) ? r.normal_sz : l_req;
      return r;
   endfunction

endpackage

// File: rtl/abs_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module abs_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/abs_smul.sv
// ---------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add product, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module abs_smul #(
   parameter int WA = 16,
   parameter int WB = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WA-1:0]    mcand,
   input  logic [WB-1:0]    mplier,
   output logic             busy,
   output logic [WA+WB-1:0] prod
);

   localparam int WP = WA + WB;
   localparam int CW = $clog2(WB + 1);

   logic [WP-1:0] acc_ff, acc_in;
   logic [WP-1:0] a_sh_ff, a_sh_in;
   logic [WB-1:0] b_sh_ff, b_sh_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;

   // One multiplier bit is consumed per cycle; the product holds afterward.
   always_comb begin
      acc_in  = acc_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         acc_in  = '0;
         a_sh_in = WP'(mcand);
         b_sh_in = mplier;
         cnt_in  = CW'(WB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_sh_ff[0]) begin
            acc_in = acc_ff + a_sh_ff;
         end
         a_sh_in = a_sh_ff << 1;
         b_sh_in = b_sh_ff >> 1;
         cnt_in  = cnt_ff - CW'(1);
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff  <= acc_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

endmodule

// File: rtl/adaptive_block_size_controller.sv
// ---------------------------------------------------------------------------
// Adaptive block size controller
// Picks the audio block size from a running mean of callback times.
// ---------------------------------------------------------------------------
// Usage:
// Each word on the req_ channel is one callback report: processing time in
// microseconds, host period in frames and an underrun flag. For each word the
// block returns one word on the rsp_ channel: the block size in force and the
// reason code of any change.
// The block takes no new word before the result word of the last one has been
// issued. The work is done by the bit-serial multipliers: sum times rate and
// count times frames run together, then the microsecond scale, then the four
// factor products in parallel lanes.
// req_stall is high while an item is in work; one item is handled at a time.
// The result sits in an output register; a stalled result holds and the next
// item is accepted meanwhile, but its result waits until the first is taken.
// Registers are written on the csr_ channel while the block is idle; writing a
// size register resets the current size to the effective normal size.
// Reset is synchronous: registers return to their defaults, the history window
// empties and the current size becomes the effective normal size.
// ---------------------------------------------------------------------------
module adaptive_block_size_controller #(
   parameter int HISTORY_DEPTH = abs_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [abs_pkg::TIME_W-1:0]      req_cb_time_us,
   input  logic [abs_pkg::FRAMES_W-1:0]    req_host_frames,
   input  logic                            req_underrun,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [abs_pkg::SIZE_W-1:0]      rsp_block_size,
   output logic [abs_pkg::REASON_W-1:0]    rsp_reason,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [abs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [abs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import abs_pkg::*;

   localparam int PTRW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNTW  = $clog2(HISTORY_DEPTH + 1);
   localparam int SUMW  = TIME_W + PTRW;
   localparam int LPW   = SUMW + RATE_W;
   localparam int LHSW  = LPW + Q_FRAC_W;
   localparam int CFW   = CNTW + FRAMES_W;
   localparam int CFMW  = CFW + USEC_W;
   localparam int SW    = CFMW + FACTOR_W;
   localparam int CMPW  = (LHSW > SW) ? LHSW : SW;
   localparam int NLANE = 4;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD    = 3'd1;
   localparam logic [2:0] ST_START = 3'd2;
   localparam logic [2:0] ST_M1    = 3'd3;
   localparam logic [2:0] ST_M2    = 3'd4;
   localparam logic [2:0] ST_M3    = 3'd5;
   localparam logic [2:0] ST_DEC   = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   // Lane order of the factor products.
   localparam int LN_FO = 0;
   localparam int LN_FU = 1;
   localparam int LN_UP = 2;
   localparam int LN_LO = 3;

   logic [2:0]          state_ff, state_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [SIZE_W-1:0]   small_req_ff, small_req_in;
   logic [SIZE_W-1:0]   normal_req_ff, normal_req_in;
   logic [SIZE_W-1:0]   large_req_ff, large_req_in;
   logic [FACTOR_W-1:0] upper_ff, upper_in;
   logic [FACTOR_W-1:0] lower_ff, lower_in;
   logic [FACTOR_W-1:0] fast_over_ff, fast_over_in;
   logic [FACTOR_W-1:0] fast_under_ff, fast_under_in;
   logic [SUMW-1:0]     sum_ff, sum_in;
   logic [CNTW-1:0]     count_ff, count_in;
   logic [PTRW-1:0]     ptr_ff, ptr_in;
   logic [SIZE_W-1:0]   cur_size_ff, cur_size_in;
   logic [FSS_W-1:0]    fss_ff, fss_in;
   logic [TIME_W-1:0]   t_ff, t_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic                urun_ff, urun_in;
   logic [SIZE_W-1:0]   res_size_ff, res_size_in;
   logic [REASON_W-1:0] res_reason_ff, res_reason_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic [REASON_W-1:0] rsp_reason_ff, rsp_reason_in;

   logic                accept, csr_wr, full;
   logic [TIME_W-1:0]   old_time;
   logic [RATE_W-1:0]   rate_eff;
   sizes_type           eff, eff_new;

   logic                start_a, start_b, start_c;
   logic                busy_lhs, busy_cf, busy_mil;
   logic [NLANE-1:0]    busy_lane;
   logic [LPW-1:0]      p_lhs;
   logic [CFW-1:0]      p_cf;
   logic [CFMW-1:0]     p_mil;
   logic [SW-1:0]       p_lane [NLANE];
   logic [FACTOR_W-1:0] lane_factor [NLANE];

   logic [CMPW-1:0]     lhs_x, fo_x, fu_x, up_x, lo_x;
   logic [FSS_W+2:0]    fss_x5;
   logic                cool_ok;
   logic [SIZE_W-1:0]   next_size;
   logic [REASON_W-1:0] next_reason;
   logic [FSS_W-1:0]    fss_base;
   logic [FSS_W:0]      fss_sum;

   assign accept    = req_valid && !req_stall;
   assign csr_wr    = csr_valid && csr_ready;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign full      = (count_ff == CNTW'(HISTORY_DEPTH));
   assign rate_eff  = (rate_ff == '0) ? RATE_DEF : rate_ff;
   assign eff       = derive_sizes(small_req_ff, normal_req_ff, large_req_ff);
   assign eff_new   = derive_sizes(small_req_in, normal_req_in, large_req_in);

   // History window storage.
   abs_ram #(
      .WIDTH (TIME_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_hist (
      .clock   (clock),
      .wr_en   (state_ff == ST_RD),
      .wr_addr (ptr_ff),
      .wr_data (t_ff),
      .rd_en   (accept),
      .rd_addr (ptr_ff),
      .rd_data (old_time)
   );

   // Multiplier start pulses, one per phase.
   assign start_a = (state_ff == ST_START);
   assign start_b = (state_ff == ST_M1) && !busy_lhs && !busy_cf;
   assign start_c = (state_ff == ST_M2) && !busy_mil;

   // Sum times rate: the left side before the Q4.12 scale.
   abs_smul #(.WA(SUMW), .WB(RATE_W)) u_mul_lhs (
      .clock (clock), .reset (reset), .start (start_a),
      .mcand (sum_ff), .mplier (rate_eff), .busy (busy_lhs), .prod (p_lhs)
   );

   // Window count times frames.
   abs_smul #(.WA(CNTW), .WB(FRAMES_W)) u_mul_cf (
      .clock (clock), .reset (reset), .start (start_a),
      .mcand (count_ff), .mplier (frames_ff), .busy (busy_cf), .prod (p_cf)
   );

   // Scale to microseconds.
   abs_smul #(.WA(CFW), .WB(USEC_W)) u_mul_usec (
      .clock (clock), .reset (reset), .start (start_b),
      .mcand (p_cf), .mplier (USEC_PER_SEC), .busy (busy_mil), .prod (p_mil)
   );

   assign lane_factor[LN_FO] = fast_over_ff;
   assign lane_factor[LN_FU] = fast_under_ff;
   assign lane_factor[LN_UP] = upper_ff;
   assign lane_factor[LN_LO] = lower_ff;

   // One lane per threshold factor.
   for (genvar g = 0; g < NLANE; g++) begin : g_lane
      abs_smul #(.WA(CFMW), .WB(FACTOR_W)) u_mul_f (
         .clock (clock), .reset (reset), .start (start_c),
         .mcand (p_mil), .mplier (lane_factor[g]), .busy (busy_lane[g]),
         .prod  (p_lane[g])
      );
   end

   // Exact threshold compares and the size decision.
   always_comb begin
      lhs_x   = CMPW'({p_lhs, {Q_FRAC_W{1'b0}}});
      fo_x    = CMPW'(p_lane[LN_FO]);
      fu_x    = CMPW'(p_lane[LN_FU]);
      up_x    = CMPW'(p_lane[LN_UP]);
      lo_x    = CMPW'(p_lane[LN_LO]);
      // Cooldown over: frames >= floor(rate/5), i.e. 5*frames + 4 >= rate.
      fss_x5  = {1'b0, fss_ff, 2'b00} + (FSS_W+3)'(fss_ff) + (FSS_W+3)'(4);
      cool_ok = (fss_x5 >= (FSS_W+3)'(rate_eff));
      next_size   = cur_size_ff;
      next_reason = RSN_NONE;
      if (urun_ff) begin
         next_size   = eff.small_sz;
         next_reason = RSN_UNDERRUN;
      end else if (lhs_x > fo_x) begin
         next_size   = eff.small_sz;
         next_reason = RSN_FAST_DOWN;
      end else if (lhs_x < fu_x) begin
         next_size   = eff.large_sz;
         next_reason = RSN_FAST_UP;
      end else if (cool_ok) begin
         if (lhs_x > up_x) begin
            if (cur_size_ff == eff.large_sz) begin
               next_size = eff.normal_sz;
            end else if (cur_size_ff == eff.normal_sz) begin
               next_size = eff.small_sz;
            end
            next_reason = RSN_SLOW_DOWN;
         end else if (lhs_x < lo_x) begin
            if (cur_size_ff == eff.small_sz) begin
               next_size = eff.normal_sz;
            end else if (cur_size_ff == eff.normal_sz) begin
               next_size = eff.large_sz;
            end
            next_reason = RSN_SLOW_UP;
         end
      end
      if (next_size == cur_size_ff) begin
         next_reason = RSN_NONE;
         fss_base    = fss_ff;
      end else begin
         fss_base    = '0;
      end
      fss_sum = {1'b0, fss_base} + (FSS_W+1)'(frames_ff);
   end

   // Sequencer, configuration writes and output register.
   always_comb begin
      state_in      = state_ff;
      rate_in       = rate_ff;
      small_req_in  = small_req_ff;
      normal_req_in = normal_req_ff;
      large_req_in  = large_req_ff;
      upper_in      = upper_ff;
      lower_in      = lower_ff;
      fast_over_in  = fast_over_ff;
      fast_under_in = fast_under_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      cur_size_in   = cur_size_ff;
      fss_in        = fss_ff;
      t_in          = t_ff;
      frames_in     = frames_ff;
      urun_in       = urun_ff;
      res_size_in   = res_size_ff;
      res_reason_in = res_reason_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_reason_in = rsp_reason_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr) begin
         case (csr_index)
            CSR_SAMPLE_RATE: rate_in       = csr_wdata;
            CSR_SMALL_SIZE:  small_req_in  = csr_wdata[SIZE_W-1:0];
            CSR_NORMAL_SIZE: normal_req_in = csr_wdata[SIZE_W-1:0];
            CSR_LARGE_SIZE:  large_req_in  = csr_wdata[SIZE_W-1:0];
            CSR_UPPER:       upper_in      = csr_wdata[FACTOR_W-1:0];
            CSR_LOWER:       lower_in      = csr_wdata[FACTOR_W-1:0];
            CSR_FAST_OVER:   fast_over_in  = csr_wdata[FACTOR_W-1:0];
            CSR_FAST_UNDER:  fast_under_in = csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
         if (csr_index == CSR_SMALL_SIZE || csr_index == CSR_NORMAL_SIZE ||
             csr_index == CSR_LARGE_SIZE) begin
            cur_size_in = eff_new.normal_sz;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               t_in      = req_cb_time_us;
               frames_in = req_host_frames;
               urun_in   = req_underrun;
               state_in  = ST_RD;
            end
         end
         ST_RD: begin
            // Oldest entry leaves the sum only once the window is full.
            sum_in = sum_ff - (full ? SUMW'(old_time) : SUMW'(0)) + SUMW'(t_ff);
            if (!full) begin
               count_in = count_ff + CNTW'(1);
            end
            ptr_in   = (ptr_ff == PTRW'(HISTORY_DEPTH - 1)) ? '0 : ptr_ff + PTRW'(1);
            state_in = ST_START;
         end
         ST_START: state_in = ST_M1;
         ST_M1: begin
            if (start_b) begin
               state_in = ST_M2;
            end
         end
         ST_M2: begin
            if (start_c) begin
               state_in = ST_M3;
            end
         end
         ST_M3: begin
            if (busy_lane == '0) begin
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            cur_size_in   = next_size;
            res_size_in   = next_size;
            res_reason_in = next_reason;
            fss_in        = fss_sum[FSS_W] ? {FSS_W{1'b1}} : fss_sum[FSS_W-1:0];
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_size_in   = res_size_ff;
               rsp_reason_in = res_reason_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rate_ff       <= RATE_RST;
         small_req_ff  <= SMALL_RST;
         normal_req_ff <= NORMAL_RST;
         large_req_ff  <= LARGE_RST;
         upper_ff      <= UPPER_RST;
         lower_ff      <= LOWER_RST;
         fast_over_ff  <= FAST_OVER_RST;
         fast_under_ff <= FAST_UNDER_RST;
         sum_ff        <= '0;
         count_ff      <= '0;
         ptr_ff        <= '0;
         cur_size_ff   <= NORMAL_RST;
         fss_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rate_ff       <= rate_in;
         small_req_ff  <= small_req_in;
         normal_req_ff <= normal_req_in;
         large_req_ff  <= large_req_in;
         upper_ff      <= upper_in;
         lower_ff      <= lower_in;
         fast_over_ff  <= fast_over_in;
         fast_under_ff <= fast_under_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         cur_size_ff   <= cur_size_in;
         fss_ff        <= fss_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      t_ff          <= t_in;
      frames_ff     <= frames_in;
      urun_ff       <= urun_in;
      res_size_ff   <= res_size_in;
      res_reason_ff <= res_reason_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_block_size = rsp_size_ff;
   assign rsp_reason     = rsp_reason_ff;

endmodule

// File: rtl/abs_checker.sv
// ---------------------------------------------------------------------------
// Block size controller checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module abs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [abs_pkg::SIZE_W-1:0]      rsp_block_size,
   input logic [abs_pkg::REASON_W-1:0]    rsp_reason
);
   import abs_pkg::*;

   // A stalled result word stays on the port.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   // A result word never carries a size below the minimum.
   `ASSERT_CLK_RST(a_size_min, clock, reset, rsp_valid |-> rsp_block_size >= SIZE_MIN)

   // The reason is always a defined code.
   `ASSERT_CLK_RST(a_reason_ok, clock, reset, rsp_valid |-> rsp_reason <= RSN_UNDERRUN)

   // After an accepted word the block is busy and takes no other.
   `ASSERT_CLK_RST(a_busy_after, clock, reset, req_valid && !req_stall |=> req_stall)

   // Reset leaves no result word pending.
   `ASSERT_CLK(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind adaptive_block_size_controller abs_checker u_abs_checker (.*);
